FILE: src/breakpoint_and_step_out_monitor_assert.svh
// Assertion macros for the breakpoint and step-out monitor.
`ifndef BREAKPOINT_AND_STEP_OUT_MONITOR_ASSERT_SVH
`define BREAKPOINT_AND_STEP_OUT_MONITOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bsm_pkg.sv
// Shared types and constants of the breakpoint and step-out monitor.
package bsm_pkg;

    // Item kinds.
    localparam logic [1:0] KIND_SET    = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_ARM    = 2'd2;
    localparam logic [1:0] KIND_FETCH  = 2'd3;

    // Result event codes.
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_SET      = 3'd1;
    localparam logic [2:0] EV_FULL     = 3'd2;
    localparam logic [2:0] EV_HIT      = 3'd3;
    localparam logic [2:0] EV_FINISH   = 3'd4;

    // Opcodes that move the subroutine depth.
    localparam logic [7:0] OP_JSR      = 8'h20;
    localparam logic [7:0] OP_RTI      = 8'h40;
    localparam logic [7:0] OP_RTS      = 8'h60;

    // Output register state of the controller.
    typedef enum logic
    {
        ST_EMPTY,
        ST_FULL
    } state_t;

    // Command from the controller to the datapath.
    typedef struct packed
    {
        logic exec;
    } ctl_cmd_t;

    // Status of the step-out tracker.
    typedef struct packed
    {
        logic armed;
        logic depth_zero;
    } dp_status_t;

endpackage

FILE: src/bsm_ctrl.sv
// Controller: handshake state machine around the result register.
module bsm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output bsm_pkg::ctl_cmd_t cmd
);

    bsm_pkg::state_t state_reg;
    bsm_pkg::state_t state_next;
    logic            accept;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsm_pkg::ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An item is taken unless a held result is stalled.
    assign accept = in_valid && !in_stall;

    // Next state: a transfer in fills the register, a transfer out empties it.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsm_pkg::ST_EMPTY:
            begin
                if (accept)
                begin
                    state_next = bsm_pkg::ST_FULL;
                end
            end
            bsm_pkg::ST_FULL:
            begin
                if (accept)
                begin
                    state_next = bsm_pkg::ST_FULL;
                end
                else if (!out_stall)
                begin
                    state_next = bsm_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                state_next = bsm_pkg::ST_EMPTY;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        in_stall  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            bsm_pkg::ST_EMPTY:
            begin
                in_stall  = 1'b0;
                out_valid = 1'b0;
            end
            bsm_pkg::ST_FULL:
            begin
                in_stall  = out_stall;
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall  = 1'b1;
                out_valid = 1'b0;
            end
        endcase
        cmd.exec = in_valid && !in_stall;
    end

endmodule

FILE: src/bsm_datapath.sv
// Datapath: breakpoint table, step-out tracker and result register.
module bsm_datapath
#(
    parameter int NUM_SLOTS  = 8,
    parameter int DEPTH_BITS = 8,
    parameter int SLOT_W     = 3,
    parameter int CNT_W      = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bsm_pkg::ctl_cmd_t     cmd,
    input  logic [1:0]            kind,
    input  logic [15:0]           address,
    input  logic [2:0]            slot_in,
    input  logic [7:0]            opcode,
    output logic [2:0]            event_res,
    output logic [2:0]            slot_out,
    output logic [3:0]            used_count,
    output bsm_pkg::dp_status_t   status,
    output logic [NUM_SLOTS-1:0]  valid_vec,
    output logic [CNT_W-1:0]      used_cnt
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    logic [NUM_SLOTS-1:0]  valid_reg;
    logic [NUM_SLOTS-1:0]  valid_next;
    logic [15:0]           addr_mem [NUM_SLOTS];
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [DEPTH_BITS-1:0] depth_reg;
    logic [DEPTH_BITS-1:0] depth_next;
    logic                  armed_reg;
    logic                  armed_next;

    logic [NUM_SLOTS-1:0]  match;
    logic [NUM_SLOTS-1:0]  clr_sel;
    logic                  hit;
    logic                  any_free;
    logic                  clr_live;
    logic [SLOT_W-1:0]     hit_idx;
    logic [SLOT_W-1:0]     free_idx;
    logic                  do_set;
    logic [2:0]            ev_next;
    logic [SLOT_W-1:0]     slot_next;
    logic [SLOT_W+2:0]     slot_wide;
    logic [CNT_W+3:0]      cnt_wide;

    // Compare every slot against the address and find the lowest hit and free slot.
    always_comb
    begin
        hit      = 1'b0;
        any_free = 1'b0;
        clr_live = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            match[i]   = valid_reg[i] && (addr_mem[i] == address);
            clr_sel[i] = (32'(slot_in) == i);
            if (match[i])
            begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = SLOT_W'(i);
            end
            if (clr_sel[i] && valid_reg[i])
            begin
                clr_live = 1'b1;
            end
        end
    end

    assign do_set = cmd.exec && (kind == bsm_pkg::KIND_SET) && any_free;

    // Next state of the table, the tracker and the result.
    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        depth_next = depth_reg;
        armed_next = armed_reg;
        ev_next    = bsm_pkg::EV_NONE;
        slot_next  = '0;
        case (kind)
            bsm_pkg::KIND_SET:
            begin
                if (any_free)
                begin
                    valid_next[free_idx] = 1'b1;
                    cnt_next             = cnt_reg + CNT_W'(1);
                    ev_next              = bsm_pkg::EV_SET;
                    slot_next            = free_idx;
                end
                else
                begin
                    ev_next = bsm_pkg::EV_FULL;
                end
            end
            bsm_pkg::KIND_CLEAR:
            begin
                valid_next = valid_reg & ~clr_sel;
                if (clr_live)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            bsm_pkg::KIND_ARM:
            begin
                depth_next = '0;
                armed_next = 1'b1;
            end
            bsm_pkg::KIND_FETCH:
            begin
                if (hit)
                begin
                    ev_next    = bsm_pkg::EV_HIT;
                    slot_next  = hit_idx;
                    armed_next = 1'b0;
                end
                else if (armed_reg)
                begin
                    if (opcode == bsm_pkg::OP_JSR)
                    begin
                        if (depth_reg != DEPTH_MAX)
                        begin
                            depth_next = depth_reg + DEPTH_BITS'(1);
                        end
                    end
                    else if (opcode == bsm_pkg::OP_RTS || opcode == bsm_pkg::OP_RTI)
                    begin
                        if (depth_reg != '0)
                        begin
                            depth_next = depth_reg - DEPTH_BITS'(1);
                        end
                        else
                        begin
                            ev_next    = bsm_pkg::EV_FINISH;
                            armed_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                ev_next = bsm_pkg::EV_NONE;
            end
        endcase
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            cnt_reg   <= '0;
            depth_reg <= '0;
            armed_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            depth_reg <= depth_next;
            armed_reg <= armed_next;
        end
    end

    // Breakpoint address store, written at the allocated slot.
    always_ff @(posedge clk)
    begin
        if (do_set)
        begin
            addr_mem[free_idx] <= address;
        end
    end

    // Result fields, masked to their port widths.
    assign slot_wide = {3'b000, slot_next};
    assign cnt_wide  = {4'b0000, cnt_next};

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            event_res  <= ev_next;
            slot_out   <= slot_wide[2:0];
            used_count <= cnt_wide[3:0];
        end
    end

    assign status.armed      = armed_reg;
    assign status.depth_zero = (depth_reg == '0);
    assign valid_vec         = valid_reg;
    assign used_cnt          = cnt_reg;

endmodule

FILE: src/breakpoint_and_step_out_monitor.sv
// A result appears on the output in the cycle after its item's transfer in.
// Throughput: one item per cycle unless the output is stalled; the slot compare,
// priority pick and depth update all finish in the cycle of the transfer, and
// the result register lets a new item enter while the previous result is taken.
// Reset clears the valid bits, the used count, the call depth and the armed flag;
// breakpoint addresses are not cleared and are read only once written.
`include "breakpoint_and_step_out_monitor_assert.svh"

module breakpoint_and_step_out_monitor
#(
    parameter int NUM_SLOTS  = 8,
    parameter int DEPTH_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] address,
    input  logic [2:0]  slot_in,
    input  logic [7:0]  opcode,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [2:0]  slot_out,
    output logic [3:0]  used_count
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

    bsm_pkg::ctl_cmd_t   cmd;
    bsm_pkg::dp_status_t status;
    logic [NUM_SLOTS-1:0] valid_vec;
    logic [CNT_W-1:0]     used_cnt;

    // Handshake controller.
    bsm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Breakpoint table and step-out tracker.
    bsm_datapath
    #(
        .NUM_SLOTS  (NUM_SLOTS),
        .DEPTH_BITS (DEPTH_BITS),
        .SLOT_W     (SLOT_W),
        .CNT_W      (CNT_W)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .kind       (kind),
        .address    (address),
        .slot_in    (slot_in),
        .opcode     (opcode),
        .event_res  (event_res),
        .slot_out   (slot_out),
        .used_count (used_count),
        .status     (status),
        .valid_vec  (valid_vec),
        .used_cnt   (used_cnt)
    );

    // The running count always matches the number of valid slots.
    `BSM_ASSERT_NOW(a_count_matches, 1'b1, $countones(valid_vec) == 32'(used_cnt), "used count out of step with valid bits")

    // A hit or a finish reported on the output leaves step-out mode disarmed.
    `BSM_ASSERT_NOW(a_event_disarms, out_valid && (event_res == bsm_pkg::EV_HIT || event_res == bsm_pkg::EV_FINISH), !status.armed, "armed after hit or finish")

    // Arming leaves the tracker armed at depth zero.
    `BSM_ASSERT_NEXT(a_arm_resets_depth, cmd.exec && kind == bsm_pkg::KIND_ARM, status.armed && status.depth_zero, "arm did not reset depth")

    // Every transfer in is followed by a result on the output.
    `BSM_ASSERT_NEXT(a_result_follows, cmd.exec, out_valid, "no result after an item")

endmodule
